>>> src/bsct_pkg.sv
// Shared types, widths and command codes for the box and sphere collision test.
package bsct_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int AXES         = 3;
   localparam int POINT_WIDTH  = 48;
   localparam int RADIUS_WIDTH = 16;
   localparam int TAG_WIDTH    = 8;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int SQ_WIDTH     = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH    = SQ_WIDTH + 2;
   localparam int RSUM_WIDTH   = RADIUS_WIDTH + 1;
   localparam int RSQ_WIDTH    = 2 * RSUM_WIDTH;
   localparam int CMP_WIDTH    = (SUM_WIDTH > RSQ_WIDTH) ? SUM_WIDTH : RSQ_WIDTH;

   typedef enum logic [1:0] {
      CMD_BOX_BOX       = 2'd0,
      CMD_BOX_SPHERE    = 2'd1,
      CMD_SPHERE_BOX    = 2'd2,
      CMD_SPHERE_SPHERE = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [TAG_WIDTH-1:0]    pair_tag;
      logic [POINT_WIDTH-1:0]  a_lo;
      logic [POINT_WIDTH-1:0]  a_hi;
      logic [RADIUS_WIDTH-1:0] a_radius;
      logic [POINT_WIDTH-1:0]  b_lo;
      logic [POINT_WIDTH-1:0]  b_hi;
      logic [RADIUS_WIDTH-1:0] b_radius;
   } req_type;

   typedef struct packed {
      logic [TAG_WIDTH-1:0] tag_out;
      logic                 hit;
   } rsp_type;

   // First stage: per-axis differences, radius sum and the box-box verdict.
   typedef struct packed {
      logic [TAG_WIDTH-1:0]             tag;
      logic                             box_box;
      logic                             overlap;
      logic [AXES-1:0][DIFF_WIDTH-1:0]  diff;
      logic [RSUM_WIDTH-1:0]            rsum;
   } prep_type;

   // Second stage: squared differences and squared radius.
   typedef struct packed {
      logic [TAG_WIDTH-1:0]           tag;
      logic                           box_box;
      logic                           overlap;
      logic [AXES-1:0][SQ_WIDTH-1:0]  sq;
      logic [RSQ_WIDTH-1:0]           rsq;
   } square_type;

   function automatic logic signed [COORD_WIDTH-1:0] coord(
      input logic [POINT_WIDTH-1:0] point,
      input int                     axis
   );
      coord = $signed(point[axis*COORD_WIDTH +: COORD_WIDTH]);
   endfunction

endpackage

>>> src/bsct_prep.sv
// First pipeline stage: clamps the sphere centre into the box and forms differences.
module bsct_prep (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bsct_pkg::req_type    in_req,
   output logic                 out_valid,
   output bsct_pkg::prep_type   out_prep
);

   logic [bsct_pkg::POINT_WIDTH-1:0]  box_lo_pt;
   logic [bsct_pkg::POINT_WIDTH-1:0]  box_hi_pt;
   logic [bsct_pkg::POINT_WIDTH-1:0]  ctr_pt;
   logic [bsct_pkg::RADIUS_WIDTH-1:0] sph_radius;
   logic                              sphere_pair;

   logic signed [bsct_pkg::COORD_WIDTH-1:0] box_lo   [bsct_pkg::AXES];
   logic signed [bsct_pkg::COORD_WIDTH-1:0] box_hi   [bsct_pkg::AXES];
   logic signed [bsct_pkg::COORD_WIDTH-1:0] ctr      [bsct_pkg::AXES];
   logic signed [bsct_pkg::COORD_WIDTH-1:0] clamped  [bsct_pkg::AXES];
   logic signed [bsct_pkg::COORD_WIDTH-1:0] a_c      [bsct_pkg::AXES];
   logic signed [bsct_pkg::COORD_WIDTH-1:0] b_c      [bsct_pkg::AXES];
   logic                                    axis_ovl [bsct_pkg::AXES];

   bsct_pkg::prep_type prep_in;
   bsct_pkg::prep_type prep_ff;
   logic               valid_in;
   logic               valid_ff;

   // Object A is the box only when the sphere is object B.
   always_comb begin
      sphere_pair = (in_req.cmd == bsct_pkg::CMD_SPHERE_SPHERE);
      if (in_req.cmd == bsct_pkg::CMD_BOX_SPHERE) begin
         box_lo_pt  = in_req.a_lo;
         box_hi_pt  = in_req.a_hi;
         ctr_pt     = in_req.b_lo;
         sph_radius = in_req.b_radius;
      end else begin
         box_lo_pt  = in_req.b_lo;
         box_hi_pt  = in_req.b_hi;
         ctr_pt     = in_req.a_lo;
         sph_radius = in_req.a_radius;
      end
   end

   always_comb begin
      prep_in.tag     = in_req.pair_tag;
      prep_in.box_box = (in_req.cmd == bsct_pkg::CMD_BOX_BOX);
      prep_in.overlap = 1'b1;
      for (int i = 0; i < bsct_pkg::AXES; i++) begin
         box_lo[i] = bsct_pkg::coord(box_lo_pt, i);
         box_hi[i] = bsct_pkg::coord(box_hi_pt, i);
         ctr[i]    = bsct_pkg::coord(ctr_pt, i);
         a_c[i]    = bsct_pkg::coord(in_req.a_lo, i);
         b_c[i]    = bsct_pkg::coord(in_req.b_lo, i);
         // Minimum is applied last, so an inverted box clamps to its minimum.
         clamped[i] = (ctr[i] < box_hi[i]) ? ctr[i] : box_hi[i];
         if (box_lo[i] > clamped[i]) begin
            clamped[i] = box_lo[i];
         end
         axis_ovl[i] = (a_c[i] <= bsct_pkg::coord(in_req.b_hi, i)) &&
                       (bsct_pkg::coord(in_req.a_hi, i) >= b_c[i]);
         prep_in.overlap = prep_in.overlap & axis_ovl[i];
         if (sphere_pair) begin
            prep_in.diff[i] = bsct_pkg::DIFF_WIDTH'(a_c[i]) - bsct_pkg::DIFF_WIDTH'(b_c[i]);
         end else begin
            prep_in.diff[i] = bsct_pkg::DIFF_WIDTH'(clamped[i]) - bsct_pkg::DIFF_WIDTH'(ctr[i]);
         end
      end
      if (sphere_pair) begin
         prep_in.rsum = bsct_pkg::RSUM_WIDTH'(in_req.a_radius) +
                        bsct_pkg::RSUM_WIDTH'(in_req.b_radius);
      end else begin
         prep_in.rsum = bsct_pkg::RSUM_WIDTH'(sph_radius);
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign out_valid = valid_ff;
   assign out_prep  = prep_ff;

endmodule

>>> src/bsct_square.sv
// Second pipeline stage: squares the per-axis differences and the radius term.
module bsct_square (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bsct_pkg::prep_type    in_prep,
   output logic                  out_valid,
   output bsct_pkg::square_type  out_square
);

   bsct_pkg::square_type square_in;
   bsct_pkg::square_type square_ff;
   logic                 valid_ff;

   logic signed [bsct_pkg::SQ_WIDTH-1:0] prod [bsct_pkg::AXES];

   always_comb begin
      square_in.tag     = in_prep.tag;
      square_in.box_box = in_prep.box_box;
      square_in.overlap = in_prep.overlap;
      for (int i = 0; i < bsct_pkg::AXES; i++) begin
         prod[i] = bsct_pkg::SQ_WIDTH'($signed(in_prep.diff[i])) *
                   bsct_pkg::SQ_WIDTH'($signed(in_prep.diff[i]));
         // A square is never negative, so the bits read as unsigned.
         square_in.sq[i] = $unsigned(prod[i]);
      end
      square_in.rsq = bsct_pkg::RSQ_WIDTH'(in_prep.rsum) * bsct_pkg::RSQ_WIDTH'(in_prep.rsum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      square_ff <= square_in;
   end

   assign out_valid  = valid_ff;
   assign out_square = square_ff;

endmodule

>>> src/bsct_reduce.sv
// Third pipeline stage: sums the squares, compares and registers the response.
module bsct_reduce (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bsct_pkg::square_type  in_square,
   output logic                  out_valid,
   output bsct_pkg::rsp_type     out_rsp
);

   logic [bsct_pkg::SUM_WIDTH-1:0] dist_sq;
   logic                           sphere_hit;
   bsct_pkg::rsp_type              rsp_in;
   bsct_pkg::rsp_type              rsp_ff;
   logic                           valid_ff;

   always_comb begin
      dist_sq = bsct_pkg::SUM_WIDTH'(in_square.sq[0]) +
                bsct_pkg::SUM_WIDTH'(in_square.sq[1]) +
                bsct_pkg::SUM_WIDTH'(in_square.sq[2]);
      // A distance equal to the radius is a miss.
      sphere_hit = bsct_pkg::CMP_WIDTH'(dist_sq) < bsct_pkg::CMP_WIDTH'(in_square.rsq);
      rsp_in.tag_out = in_square.tag;
      rsp_in.hit     = in_square.box_box ? in_square.overlap : sphere_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

>>> src/box_sphere_collision_test_unit.sv
// Top level of the pipelined box and sphere collision test.
//
//   channel   direction  handshake          payload
//   request   in         start / busy       req_item  (bsct_pkg::req_type)
//   response  out        rsp_valid strobe   rsp_item  (bsct_pkg::rsp_type)
//
// One request is taken in every cycle while busy is low; its response passes the clamp and difference,
// multiplier and compare registers and comes out one per request and in order.
// The pipeline has three register stages: clamp and difference, the 17 by 17 multipliers,
// sum and compare.
// Reset clears the stage valid bits; busy is high during reset and the cycle after.
// The response strobe lasts one cycle and cannot be held off, so nothing stalls.
module box_sphere_collision_test_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bsct_pkg::req_type  req_item,
   output logic               rsp_valid,
   output bsct_pkg::rsp_type  rsp_item
);

   logic                 busy_ff;
   logic                 busy_in;
   logic                 accept;
   logic                 prep_valid;
   bsct_pkg::prep_type   prep;
   logic                 square_valid;
   bsct_pkg::square_type square;

   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy   = busy_ff | reset;
   assign accept = start & ~busy;

   bsct_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_item),
      .out_valid (prep_valid),
      .out_prep  (prep)
   );

   bsct_square u_square (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (prep_valid),
      .in_prep    (prep),
      .out_valid  (square_valid),
      .out_square (square)
   );

   bsct_reduce u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (square_valid),
      .in_square (square),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_item)
   );

endmodule

>>> src/bsct_checker.sv
// Port-level checks for the collision test unit, with the bind that attaches them.
module bsct_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input bsct_pkg::req_type  req_item,
   input logic               rsp_valid,
   input bsct_pkg::rsp_type  rsp_item
);

   // Every response stems from a request that was taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("response without a matching request");

   // A request not cut off by reset always yields its response.
   assert property (@(posedge clock) disable iff (reset)
      ($past(start && !busy, 3) && !$past(reset, 1) && !$past(reset, 2)) |-> rsp_valid)
      else $error("request lost in the pipeline");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.tag_out == $past(req_item.pair_tag, 3)))
      else $error("response tag does not match its request");

   // Two concentric spheres with some radius always intersect.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy
         && req_item.cmd == bsct_pkg::CMD_SPHERE_SPHERE
         && req_item.a_lo == req_item.b_lo
         && (req_item.a_radius != '0 || req_item.b_radius != '0), 3)) |-> rsp_item.hit)
      else $error("concentric spheres reported as a miss");

endmodule

bind box_sphere_collision_test_unit bsct_checker u_bsct_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
